// ----- hdl/mau_pkg.sv -----
package mau_pkg;

  localparam int MOD_W  = 31;
  localparam int OPND_W = 63;
  localparam int OP_W   = 3;
  localparam int CNT_W  = $clog2(OPND_W);

  localparam logic [MOD_W-1:0] RESET_MODULUS = MOD_W'(1000000007);

  // start value of the down counter for a reduction pass and for a multiply pass
  localparam logic [CNT_W-1:0] LAST_RED = CNT_W'(OPND_W - 1);
  localparam logic [CNT_W-1:0] LAST_MUL = CNT_W'(MOD_W - 1);

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_POW = 3'd3;
  localparam logic [OP_W-1:0] OP_INV = 3'd4;

endpackage

// ----- hdl/mau_step.sv -----
// one modular step: ((dbl ? 2r : r) mod m + addend) mod m, with r < m, addend <= m
module mau_step (
  input  logic [mau_pkg::MOD_W-1:0] r,
  input  logic [mau_pkg::MOD_W-1:0] addend,
  input  logic [mau_pkg::MOD_W-1:0] modulus,
  input  logic                      dbl,
  output logic [mau_pkg::MOD_W-1:0] res
);
  import mau_pkg::*;

  logic [MOD_W:0]   t;
  logic [MOD_W:0]   m_ext;
  logic [MOD_W-1:0] t_red;
  logic [MOD_W:0]   s;

  assign m_ext = {1'b0, modulus};
  assign t     = dbl ? {r, 1'b0} : {1'b0, r};

  always_comb begin
    if (t >= m_ext) begin
      t_red = MOD_W'(t - m_ext);
    end else begin
      t_red = t[MOD_W-1:0];
    end
  end

  assign s = {1'b0, t_red} + {1'b0, addend};

  always_comb begin
    if (s >= m_ext) begin
      res = MOD_W'(s - m_ext);
    end else begin
      res = s[MOD_W-1:0];
    end
  end

endmodule

// ----- hdl/modular_arithmetic_unit.sv -----
// from request accept to out_valid rising: add/subtract reduce a and b, then add; multiply
// reduces a and b, then multiplies; power squares per exponent bit up to the top set one and
// multiplies per set bit, as does inverse; a reserved code or modulus below 2 goes to S_FIN
// one request at a time, in_ready back in the same cycle that out_valid rises; every step goes
// through the shared mau_step unit, one operand bit per cycle
// reset: modulus returns to 1000000007, any request in flight is dropped
module modular_arithmetic_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mau_pkg::MOD_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mau_pkg::OP_W-1:0]   in_operation,
  input  logic [mau_pkg::OPND_W-1:0] in_operand_a,
  input  logic [mau_pkg::OPND_W-1:0] in_operand_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mau_pkg::MOD_W-1:0]  out_result
);
  import mau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_B, S_ADD, S_MUL, S_POW, S_PMUL, S_PSQR, S_FIN
  } state_t;

  localparam int PAD_W = OPND_W - MOD_W;

  state_t             state_r, state_nxt;
  logic [MOD_W-1:0]   modulus_r, modulus_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0]   out_result_r, out_result_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [OPND_W-1:0]  a_r, a_nxt;
  logic [OPND_W-1:0]  b_r, b_nxt;
  logic [OPND_W-1:0]  sh_r, sh_nxt;
  logic [OPND_W-1:0]  exp_r, exp_nxt;
  logic [MOD_W-1:0]   w_r, w_nxt;
  logic [MOD_W-1:0]   mx_r, mx_nxt;
  logic [MOD_W-1:0]   ar_r, ar_nxt;
  logic [MOD_W-1:0]   br_r, br_nxt;
  logic [MOD_W-1:0]   acc_r, acc_nxt;
  logic [MOD_W-1:0]   base_r, base_nxt;
  logic [MOD_W-1:0]   res_r, res_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [MOD_W-1:0]   unit_r;
  logic [MOD_W-1:0]   unit_add;
  logic               unit_dbl;
  logic [MOD_W-1:0]   unit_out;
  logic [MOD_W-1:0]   sub_add;
  logic [OPND_W-1:0]  exp_init;
  logic [MOD_W-1:0]   one;

  assign one       = {{(MOD_W-1){1'b0}}, 1'b1};
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

  // m - br is m itself when br is zero, so feed zero there
  assign sub_add  = (br_r == '0) ? '0 : modulus_r - br_r;
  assign exp_init = (op_r == OP_POW) ? b_r
                                     : {{PAD_W{1'b0}}, modulus_r - MOD_W'(2)};

  always_comb begin
    unit_r   = w_r;
    unit_dbl = 1'b1;
    unit_add = '0;
    unique case (state_r) inside
      S_ADD: begin
        unit_r   = ar_r;
        unit_dbl = 1'b0;
        unit_add = (op_r == OP_SUB) ? sub_add : br_r;
      end
      S_RED_A, S_RED_B: begin
        unit_add = {{(MOD_W-1){1'b0}}, sh_r[OPND_W-1]};
      end
      S_MUL, S_PMUL, S_PSQR: begin
        unit_add = sh_r[OPND_W-1] ? mx_r : '0;
      end
      default: begin
        unit_add = '0;
      end
    endcase
  end

  mau_step u_step (
    .r       (unit_r),
    .addend  (unit_add),
    .modulus (modulus_r),
    .dbl     (unit_dbl),
    .res     (unit_out)
  );

  always_comb begin
    state_nxt      = state_r;
    modulus_nxt    = modulus_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    sh_nxt   = sh_r;
    exp_nxt  = exp_r;
    w_nxt    = w_r;
    mx_nxt   = mx_r;
    ar_nxt   = ar_r;
    br_nxt   = br_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;

    if (cfg_valid && cfg_ready) begin
      modulus_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          a_nxt  = in_operand_a;
          b_nxt  = in_operand_b;
          if (modulus_r < MOD_W'(2) || in_operation > OP_INV) begin
            res_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            w_nxt     = '0;
            sh_nxt    = in_operand_a;
            cnt_nxt   = LAST_RED;
            state_nxt = S_RED_A;
          end
        end
      end
      S_RED_A: begin
        w_nxt   = unit_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          ar_nxt = unit_out;
          if (op_r == OP_POW || op_r == OP_INV) begin
            exp_nxt  = exp_init;
            acc_nxt  = one;
            base_nxt = unit_out;
            // zero to the zero is tested on the raw base
            if (a_r == '0 && exp_init == '0) begin
              res_nxt   = '0;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_POW;
            end
          end else begin
            w_nxt     = '0;
            sh_nxt    = b_r;
            cnt_nxt   = LAST_RED;
            state_nxt = S_RED_B;
          end
        end
      end
      S_RED_B: begin
        w_nxt   = unit_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          br_nxt = unit_out;
          if (op_r == OP_MUL) begin
            w_nxt     = '0;
            mx_nxt    = ar_r;
            sh_nxt    = {unit_out, {PAD_W{1'b0}}};
            cnt_nxt   = LAST_MUL;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        res_nxt   = unit_out;
        state_nxt = S_FIN;
      end
      S_MUL: begin
        w_nxt   = unit_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_nxt   = unit_out;
          state_nxt = S_FIN;
        end
      end
      S_POW: begin
        if (exp_r == '0) begin
          res_nxt   = acc_r;
          state_nxt = S_FIN;
        end else begin
          w_nxt   = '0;
          cnt_nxt = LAST_MUL;
          sh_nxt  = {base_r, {PAD_W{1'b0}}};
          if (exp_r[0]) begin
            mx_nxt    = acc_r;
            state_nxt = S_PMUL;
          end else begin
            mx_nxt    = base_r;
            state_nxt = S_PSQR;
          end
        end
      end
      S_PMUL: begin
        w_nxt   = unit_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          acc_nxt   = unit_out;
          w_nxt     = '0;
          mx_nxt    = base_r;
          sh_nxt    = {base_r, {PAD_W{1'b0}}};
          cnt_nxt   = LAST_MUL;
          state_nxt = S_PSQR;
        end
      end
      S_PSQR: begin
        w_nxt   = unit_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          base_nxt  = unit_out;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_POW;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    sh_r   <= sh_nxt;
    exp_r  <= exp_nxt;
    w_r    <= w_nxt;
    mx_r   <= mx_nxt;
    ar_r   <= ar_nxt;
    br_r   <= br_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= RESET_MODULUS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/mau_checker.sv -----
module mau_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mau_pkg::MOD_W-1:0]  out_result
);
  import mau_pkg::*;

  // after reset nothing is pending and a request can be taken
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not clean after reset");

  // a request keeps the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  // no result can show up in the cycle right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result)))
    else $error("stalled result changed");

  // a reduced value never reaches the largest modulus
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result != {MOD_W{1'b1}}))
    else $error("result out of range");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_result   (out_result)
);

// ----- verif/modular_arithmetic_unit_tb.sv -----
module modular_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mau_pkg::*;

  // codes the block does not implement, answered with zero
  localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

  localparam logic [OPND_W-1:0] OPND_MAX = {OPND_W{1'b1}};
  localparam logic [MOD_W-1:0]  MOD_MAX  = {MOD_W{1'b1}};

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MOD_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [OPND_W-1:0] in_operand_a;
  logic [OPND_W-1:0] in_operand_b;
  logic              out_valid;
  logic              out_ready;
  logic [MOD_W-1:0]  out_result;

  logic [MOD_W-1:0] model_modulus;
  logic [MOD_W-1:0] pending_results[$];
  int               error_count;
  int               request_count;
  int               result_count;
  int               modulus_writes;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               hold_ticket;
  int               hold_len;

  modular_arithmetic_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("modular_arithmetic_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] mod_power(input logic [OPND_W-1:0] base,
                                            input logic [OPND_W-1:0] expo,
                                            input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    int          i;
    // zero to the zero is checked on the unreduced base
    if (base == '0 && expo == '0) return 64'd0;
    acc = 64'd1 % m;
    sq  = 64'(base) % m;
    for (i = 0; i < OPND_W; i++) begin
      if (expo[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc;
  endfunction

  function automatic logic [MOD_W-1:0] modular_result(input logic [OP_W-1:0] op,
                                                      input logic [OPND_W-1:0] a,
                                                      input logic [OPND_W-1:0] b);
    logic [63:0] m;
    logic [63:0] ar;
    logic [63:0] br;
    logic [63:0] r;
    m = 64'(model_modulus);
    if (m < 64'd2) return '0;
    ar = 64'(a) % m;
    br = 64'(b) % m;
    case (op)
      OP_ADD:  r = (ar + br) % m;
      OP_SUB:  r = (ar + m - br) % m;
      OP_MUL:  r = (ar * br) % m;
      OP_POW:  r = mod_power(a, b, m);
      OP_INV:  r = mod_power(a, OPND_W'(m - 64'd2), m);
      default: r = 64'd0;
    endcase
    return r[MOD_W-1:0];
  endfunction

  // ---------------------------------------------------------------- random helpers

  function automatic int idle_gap(input int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [OPND_W-1:0] rand_operand(input logic [MOD_W-1:0] m);
    logic [63:0] wide;
    case ($urandom_range(0, 5))
      0:       wide = {$urandom, $urandom};
      1:       wide = 64'($urandom_range(0, 15));
      // close to a multiple of the modulus
      2:       wide = 64'($urandom) * m + 64'($urandom_range(0, 2));
      3:       wide = 64'($urandom_range(1, 1 << 20)) * m - 64'd1;
      4:       wide = {$urandom, $urandom} >> $urandom_range(0, 62);
      default: wide = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'(OPND_MAX);
    endcase
    return wide[OPND_W-1:0];
  endfunction

  function automatic logic [OPND_W-1:0] rand_exponent(input logic [MOD_W-1:0] m);
    logic [63:0] wide;
    int          pick;
    pick = $urandom_range(0, 99);
    // mostly short exponents, a share of full width ones
    if (pick < 8)       wide = 64'($urandom_range(0, 2));
    else if (pick < 75) wide = {$urandom, $urandom} >> (64 - $urandom_range(1, 20));
    else if (pick < 90) wide = {$urandom, $urandom};
    else                wide = 64'(m) - 64'($urandom_range(1, 2));
    return wide[OPND_W-1:0];
  endfunction

  // ---------------------------------------------------------------- request side

  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic [OPND_W-1:0] a,
                              input logic [OPND_W-1:0] b);
    int gap;
    gap = idle_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, modular_result(op, a, b)};
    request_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model_modulus = value;
    cfg_valid <= 1'b0;
    modulus_writes++;
  endtask

  task automatic send_random_request();
    logic [OP_W-1:0]   op;
    logic [OPND_W-1:0] b;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      op = OP_ADD;
    else if (pick < 40) op = OP_SUB;
    else if (pick < 60) op = OP_MUL;
    else if (pick < 80) op = OP_POW;
    else if (pick < 92) op = OP_INV;
    else begin
      case ($urandom_range(0, 2))
        0:       op = OP_RSVD_LO;
        1:       op = OP_RSVD_MID;
        default: op = OP_RSVD_HI;
      endcase
    end
    b = (op == OP_POW) ? rand_exponent(model_modulus) : rand_operand(model_modulus);
    send_request(op, rand_operand(model_modulus), b);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_modulus_corners();
    logic [OPND_W-1:0] rm;
    rm = OPND_W'(RESET_MODULUS);
    tx_idle_pct = 0;
    send_request(OP_ADD, OPND_MAX, OPND_MAX);
    send_request(OP_ADD, '0, '0);
    send_request(OP_SUB, '0, OPND_MAX);
    send_request(OP_SUB, OPND_MAX, '0);
    send_request(OP_MUL, OPND_MAX, OPND_MAX);
    send_request(OP_MUL, rm - 1, rm - 1);
    send_request(OP_POW, '0, '0);
    // multiple of m with exponent zero still gives one
    send_request(OP_POW, rm * 3, '0);
    send_request(OP_POW, 63'd12345, '0);
    send_request(OP_POW, OPND_MAX, OPND_MAX);
    send_request(OP_POW, rm * 7, 63'd5);
    send_request(OP_INV, '0, OPND_MAX);
    send_request(OP_INV, rm, '0);
    send_request(OP_INV, OPND_MAX, '0);
    send_request(OP_RSVD_LO, OPND_MAX, OPND_MAX);
    send_request(OP_RSVD_MID, OPND_MAX, 63'd1);
    send_request(OP_RSVD_HI, 63'd1, OPND_MAX);
  endtask

  task automatic test_modulus_two();
    write_modulus(MOD_W'(2));
    // inverse exponent is zero here
    send_request(OP_INV, '0, '0);
    send_request(OP_INV, 63'd1, OPND_MAX);
    send_request(OP_INV, 63'd2, '0);
    send_request(OP_POW, '0, '0);
    send_request(OP_MUL, OPND_MAX, OPND_MAX);
  endtask

  task automatic test_degenerate_modulus();
    write_modulus('0);
    send_request(OP_ADD, OPND_MAX, 63'd1);
    send_request(OP_POW, 63'd3, 63'd4);
    write_modulus(MOD_W'(1));
    send_request(OP_INV, 63'd5, '0);
    send_request(OP_MUL, 63'd3, 63'd3);
  endtask

  task automatic test_output_backpressure();
    write_modulus(MOD_MAX);
    tx_idle_pct = 0;
    hold_len    <= 6000;
    hold_ticket <= hold_ticket + 1;
    send_request(OP_POW, OPND_MAX, OPND_MAX);
    send_request(OP_INV, OPND_MAX, '0);
    send_request(OP_MUL, rand_operand(MOD_MAX), rand_operand(MOD_MAX));
    send_request(OP_ADD, rand_operand(MOD_MAX), rand_operand(MOD_MAX));
    send_request(OP_SUB, rand_operand(MOD_MAX), rand_operand(MOD_MAX));
    send_request(OP_POW, rand_operand(MOD_MAX), rand_exponent(MOD_MAX));
  endtask

  task automatic test_random_traffic();
    logic [MOD_W-1:0] moduli [9];
    int               phase;
    moduli[0] = MOD_MAX;
    moduli[1] = RESET_MODULUS;
    moduli[2] = MOD_W'(998244353);
    moduli[3] = MOD_W'(2);
    moduli[4] = MOD_W'(3);
    moduli[5] = MOD_W'(97);
    moduli[6] = MOD_W'(65537);
    moduli[7] = MOD_W'($urandom_range(2, 2147483647));
    moduli[8] = MOD_W'($urandom_range(2, 300));
    for (phase = 0; phase < 9; phase++) begin
      write_modulus(moduli[phase]);
      // vary idling per phase, including phases with none on either side
      tx_idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 25 : 60);
      rx_idle_pct = ((phase / 3) % 3 == 0) ? 0 : (((phase / 3) % 3 == 1) ? 60 : 25);
      repeat (93) send_random_request();
    end
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_checker
    int               hold_left;
    int               tickets_seen;
    int               stall_left;
    logic [MOD_W-1:0] want;
    hold_left    = 0;
    tickets_seen = 0;
    stall_left   = 0;
    out_ready    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $error("result: expected none, got %0d", out_result);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_result !== want) begin
            $error("result: expected %0d, got %0d", want, out_result);
            error_count++;
          end
        end
      end
      if (hold_ticket != tickets_seen) begin
        tickets_seen = hold_ticket;
        hold_left    = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_gap(rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_operation   = OP_ADD;
    in_operand_a   = '0;
    in_operand_b   = '0;
    model_modulus  = RESET_MODULUS;
    error_count    = 0;
    request_count  = 0;
    result_count   = 0;
    modulus_writes = 0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 30;
    hold_ticket    = 0;
    hold_len       = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_modulus_corners();
    test_modulus_two();
    test_degenerate_modulus();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (5000) @(posedge clk);
    $display("covered %0d requests across %0d modulus writes, %0d results compared",
             request_count, modulus_writes, result_count);
    $display("all five operations, reserved codes, modulus 0 to 2^31-1, output held off");
    if (error_count == 0) begin
      $display("modular_arithmetic_unit: match");
    end else begin
      $display("modular_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mau_pkg.sv
hdl/mau_step.sv
hdl/modular_arithmetic_unit.sv
hdl/mau_checker.sv
verif/modular_arithmetic_unit_tb.sv
